[sv/bsas_pkg.sv]
`timescale 1ns / 1ps

package bsas_pkg;

  // Field widths
  localparam int PlainW   = 60;
  localparam int ModW     = 61;
  localparam int FixW     = 64;
  localparam int ProdW    = 122;
  localparam int FixNumW  = 120;
  localparam int CfgIdxW  = 3;

  // Number of RNS moduli in use (1 to 3)
  localparam int NumModuli = 3;

  // Restoring-division pipeline depths, one restoring step per stage
  localparam int FixSteps = FixNumW;
  localparam int ModSteps = ProdW;

  // Opcodes
  localparam logic OpAdd = 1'b0;
  localparam logic OpSub = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPlainModulus = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgQModPlain    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgModulusZero  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgModulusOne   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgModulusTwo   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDeltaZero    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgDeltaOne     = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgDeltaTwo     = 3'd7;

  typedef struct packed {
    logic [PlainW-1:0] pt_modulus;
    logic [PlainW-1:0] q_mod_plain;
    logic [ModW-1:0]   modulus_zero;
    logic [ModW-1:0]   modulus_one;
    logic [ModW-1:0]   modulus_two;
    logic [ModW-1:0]   delta_zero;
    logic [ModW-1:0]   delta_one;
    logic [ModW-1:0]   delta_two;
  } cfg_t;

  // Sideband that travels with each beat through the pipeline
  typedef struct packed {
    logic              op;
    logic [1:0]        idx;
    logic [PlainW-1:0] m;
    logic [ModW-1:0]   res;
    logic [FixW-1:0]   fix;
  } item_t;

  function automatic logic [ModW-1:0] mod_of(input cfg_t c, input logic [1:0] idx);
    logic [ModW-1:0] r;
    unique case (idx)
      2'd0:    r = c.modulus_zero;
      2'd1:    r = c.modulus_one;
      default: r = c.modulus_two;
    endcase
    return r;
  endfunction

  function automatic logic [ModW-1:0] delta_of(input cfg_t c, input logic [1:0] idx);
    logic [ModW-1:0] r;
    unique case (idx)
      2'd0:    r = c.delta_zero;
      2'd1:    r = c.delta_one;
      default: r = c.delta_two;
    endcase
    return r;
  endfunction

  function automatic logic idx_ok(input logic [1:0] idx);
    return (idx < NumModuli);
  endfunction

endpackage

[sv/bsas_mul.sv]
`timescale 1ns / 1ps

// Three-stage 60x61 multiply plus 64-bit addend, built from 30x31 and 30x30 partial products
module bsas_mul import bsas_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [PlainW-1:0] a,
  input  logic [ModW-1:0]   b,
  input  logic [FixW-1:0]   c,
  input  item_t             in_item,
  output logic              out_valid,
  output logic [ProdW-1:0]  out_sum,
  output item_t             out_item
);

  logic [2:0] v_r;

  logic [60:0] p00_nxt, p00_r;
  logic [59:0] p01_nxt, p01_r;
  logic [60:0] p10_nxt, p10_r;
  logic [59:0] p11_nxt, p11_r;
  logic [FixW-1:0] c1_r, c2_r;
  item_t it1_r, it2_r, it3_r;

  logic [120:0] sa_nxt, sa_r;
  logic [91:0]  sb_nxt, sb_r;
  logic [ProdW-1:0] sum_nxt, sum_r;

  // Partial products
  assign p00_nxt = 61'(a[29:0]) * 61'(b[30:0]);
  assign p01_nxt = 60'(a[29:0]) * 60'(b[60:31]);
  assign p10_nxt = 61'(a[59:30]) * 61'(b[30:0]);
  assign p11_nxt = 60'(a[59:30]) * 60'(b[60:31]);

  // Fold partial products into two words
  assign sa_nxt = {p11_r, p00_r};
  assign sb_nxt = 92'({p01_r, 31'b0}) + 92'({p10_r, 30'b0});

  // Final three-way add
  assign sum_nxt = 122'(sa_r) + 122'(sb_r) + 122'(c2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= p00_nxt;
      p01_r <= p01_nxt;
      p10_r <= p10_nxt;
      p11_r <= p11_nxt;
      c1_r  <= c;
      it1_r <= in_item;
      sa_r  <= sa_nxt;
      sb_r  <= sb_nxt;
      c2_r  <= c1_r;
      it2_r <= it1_r;
      sum_r <= sum_nxt;
      it3_r <= it2_r;
    end
  end

  assign out_valid = v_r[2];
  assign out_sum   = sum_r;
  assign out_item  = it3_r;

endmodule

[sv/bsas_fix_div.sv]
`timescale 1ns / 1ps

// Rounding-fix divider: one restoring step per stage over the 120-bit numerator.
// The last 61 stages also reduce the residue by its RNS modulus.
module bsas_fix_div import bsas_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  cfg_t               cfg,
  input  logic               in_valid,
  input  logic [FixNumW-1:0] num,
  input  item_t              in_item,
  output logic               out_valid,
  output item_t              out_item
);

  localparam int ResStart = FixSteps - ModW;

  logic               v_r    [FixSteps];
  logic [FixNumW-1:0] num_r  [FixSteps];
  logic [PlainW-1:0]  rem_r  [FixSteps];
  logic [FixW-1:0]    quo_r  [FixSteps];
  logic [ModW-1:0]    rsh_r  [FixSteps];
  logic [ModW-1:0]    rres_r [FixSteps];
  item_t              it_r   [FixSteps];

  logic               src_v    [FixSteps];
  logic [FixNumW-1:0] src_num  [FixSteps];
  logic [PlainW-1:0]  src_rem  [FixSteps];
  logic [FixW-1:0]    src_quo  [FixSteps];
  logic [ModW-1:0]    src_rsh  [FixSteps];
  logic [ModW-1:0]    src_rres [FixSteps];
  item_t              src_it   [FixSteps];

  logic [FixNumW-1:0] num_nxt  [FixSteps];
  logic [PlainW-1:0]  rem_nxt  [FixSteps];
  logic [FixW-1:0]    quo_nxt  [FixSteps];
  logic [ModW-1:0]    rsh_nxt  [FixSteps];
  logic [ModW-1:0]    rres_nxt [FixSteps];

  // Stage inputs: first stage from the port, others from the stage before
  always_comb begin
    src_v[0]    = in_valid;
    src_num[0]  = num;
    src_rem[0]  = '0;
    src_quo[0]  = '0;
    src_rsh[0]  = in_item.res;
    src_rres[0] = '0;
    src_it[0]   = in_item;
    for (int s = 1; s < FixSteps; s++) begin
      src_v[s]    = v_r[s-1];
      src_num[s]  = num_r[s-1];
      src_rem[s]  = rem_r[s-1];
      src_quo[s]  = quo_r[s-1];
      src_rsh[s]  = rsh_r[s-1];
      src_rres[s] = rres_r[s-1];
      src_it[s]   = it_r[s-1];
    end
  end

  // One restoring step per stage
  always_comb begin
    logic [PlainW:0] rem2;
    logic            ge;
    logic [ModW:0]   rr2;
    logic [ModW-1:0] md;
    logic            ge2;
    for (int s = 0; s < FixSteps; s++) begin
      rem2 = {src_rem[s], src_num[s][FixNumW-1]};
      ge   = (rem2 >= {1'b0, cfg.pt_modulus});
      rem_nxt[s] = ge ? PlainW'(rem2 - {1'b0, cfg.pt_modulus}) : rem2[PlainW-1:0];
      quo_nxt[s] = {src_quo[s][FixW-2:0], ge};
      num_nxt[s] = {src_num[s][FixNumW-2:0], 1'b0};
      md  = mod_of(cfg, src_it[s].idx);
      rr2 = {src_rres[s], src_rsh[s][ModW-1]};
      ge2 = (rr2 >= {1'b0, md});
      if (s >= ResStart) begin
        rres_nxt[s] = ge2 ? ModW'(rr2 - {1'b0, md}) : rr2[ModW-1:0];
        rsh_nxt[s]  = {src_rsh[s][ModW-2:0], 1'b0};
      end else begin
        rres_nxt[s] = src_rres[s];
        rsh_nxt[s]  = src_rsh[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < FixSteps; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      for (int s = 0; s < FixSteps; s++) v_r[s] <= src_v[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < FixSteps; s++) begin
        num_r[s]  <= num_nxt[s];
        rem_r[s]  <= rem_nxt[s];
        quo_r[s]  <= quo_nxt[s];
        rsh_r[s]  <= rsh_nxt[s];
        rres_r[s] <= rres_nxt[s];
        it_r[s]   <= src_it[s];
      end
    end
  end

  // Zero plain modulus gives no fix; out-of-range index keeps the raw residue
  always_comb begin
    out_item     = it_r[FixSteps-1];
    out_item.fix = (cfg.pt_modulus == '0) ? '0 : quo_r[FixSteps-1];
    if (idx_ok(it_r[FixSteps-1].idx)) begin
      out_item.res = rres_r[FixSteps-1];
    end
  end

  assign out_valid = v_r[FixSteps-1];

endmodule

[sv/bsas_mod_div.sv]
`timescale 1ns / 1ps

// Reduce m*delta + fix by the selected modulus: one restoring step per stage
module bsas_mod_div import bsas_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  cfg_t             cfg,
  input  logic             in_valid,
  input  logic [ProdW-1:0] num,
  input  item_t            in_item,
  output logic             out_valid,
  output logic [ModW-1:0]  out_scaled,
  output item_t            out_item
);

  logic             v_r   [ModSteps];
  logic [ProdW-1:0] num_r [ModSteps];
  logic [ModW-1:0]  rem_r [ModSteps];
  item_t            it_r  [ModSteps];

  logic             src_v   [ModSteps];
  logic [ProdW-1:0] src_num [ModSteps];
  logic [ModW-1:0]  src_rem [ModSteps];
  item_t            src_it  [ModSteps];

  logic [ProdW-1:0] num_nxt [ModSteps];
  logic [ModW-1:0]  rem_nxt [ModSteps];

  always_comb begin
    src_v[0]   = in_valid;
    src_num[0] = num;
    src_rem[0] = '0;
    src_it[0]  = in_item;
    for (int s = 1; s < ModSteps; s++) begin
      src_v[s]   = v_r[s-1];
      src_num[s] = num_r[s-1];
      src_rem[s] = rem_r[s-1];
      src_it[s]  = it_r[s-1];
    end
  end

  // Shift in one numerator bit, subtract the modulus when it fits
  always_comb begin
    logic [ModW:0]   rem2;
    logic [ModW-1:0] md;
    for (int s = 0; s < ModSteps; s++) begin
      md   = mod_of(cfg, src_it[s].idx);
      rem2 = {src_rem[s], src_num[s][ProdW-1]};
      rem_nxt[s] = (rem2 >= {1'b0, md}) ? ModW'(rem2 - {1'b0, md}) : rem2[ModW-1:0];
      num_nxt[s] = {src_num[s][ProdW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ModSteps; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      for (int s = 0; s < ModSteps; s++) v_r[s] <= src_v[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < ModSteps; s++) begin
        num_r[s] <= num_nxt[s];
        rem_r[s] <= rem_nxt[s];
        it_r[s]  <= src_it[s];
      end
    end
  end

  assign out_valid  = v_r[ModSteps-1];
  assign out_scaled = rem_r[ModSteps-1];
  assign out_item   = it_r[ModSteps-1];

endmodule

[sv/bfv_scaled_plain_add_sub.sv]
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// in_       in_valid / in_stall  in_opcode, in_plain_coeff, in_modulus_index, in_residue_in
// out_      out_valid / out_stall out_residue_out
// cfg_      cfg_wr_en            cfg_index, cfg_wr_data
//
// One beat enters per cycle while in_stall is low. Each beat passes through the fix multiply,
// the fix divider (one quotient bit per stage), the m*delta multiply, the modulus
// reduction and the final add/subtract and output register, in that order.
// Reset (rst_n low, synchronous) clears all valid bits and loads register defaults.
// A stalled output beat freezes the whole pipeline and raises in_stall.
module bfv_scaled_plain_add_sub import bsas_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [PlainW-1:0]  in_plain_coeff,
  input  logic [1:0]         in_modulus_index,
  input  logic [ModW-1:0]    in_residue_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ModW-1:0]    out_residue_out,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ModW-1:0]    cfg_wr_data
);

  cfg_t cfg_r;

  logic en;
  logic out_valid_r;
  logic [ModW-1:0] out_residue_r;
  logic [1:0] out_idx_r;

  item_t in_item;
  logic [ModW-1:0] half_t;
  logic [ModW:0]   t_plus;

  logic m1_valid, fd_valid, m2_valid, md_valid;
  logic [ProdW-1:0] m1_sum, m2_sum;
  item_t m1_item, fd_item, m2_item, md_item;
  logic [ModW-1:0] md_scaled;

  logic [ModW-1:0] sel_mod;
  logic [ModW:0]   add_sum;
  logic [ModW:0]   sub_wrap;
  logic [ModW-1:0] res_nxt;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pt_modulus    <= 60'd65537;
      cfg_r.q_mod_plain   <= '0;
      cfg_r.modulus_zero  <= 61'd2;
      cfg_r.modulus_one   <= 61'd2;
      cfg_r.modulus_two   <= 61'd2;
      cfg_r.delta_zero    <= '0;
      cfg_r.delta_one     <= '0;
      cfg_r.delta_two     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CfgPlainModulus: cfg_r.pt_modulus    <= cfg_wr_data[PlainW-1:0];
        CfgQModPlain:    cfg_r.q_mod_plain   <= cfg_wr_data[PlainW-1:0];
        CfgModulusZero:  cfg_r.modulus_zero  <= cfg_wr_data;
        CfgModulusOne:   cfg_r.modulus_one   <= cfg_wr_data;
        CfgModulusTwo:   cfg_r.modulus_two   <= cfg_wr_data;
        CfgDeltaZero:    cfg_r.delta_zero    <= cfg_wr_data;
        CfgDeltaOne:     cfg_r.delta_one     <= cfg_wr_data;
        CfgDeltaTwo:     cfg_r.delta_two     <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless the output beat is held
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Rounding threshold (t+1)/2
  assign t_plus = {1'b0, ModW'(cfg_r.pt_modulus)} + 62'd1;
  assign half_t = t_plus[ModW:1];

  always_comb begin
    in_item.op  = in_opcode;
    in_item.idx = in_modulus_index;
    in_item.m   = in_plain_coeff;
    in_item.res = in_residue_in;
    in_item.fix = '0;
  end

  // q_mod_plain * m + (t+1)/2
  bsas_mul u_mul_fix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .a         (cfg_r.q_mod_plain),
    .b         ({1'b0, in_plain_coeff}),
    .c         (FixW'(half_t)),
    .in_item   (in_item),
    .out_valid (m1_valid),
    .out_sum   (m1_sum),
    .out_item  (m1_item)
  );

  bsas_fix_div u_fix_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg_r),
    .in_valid  (m1_valid),
    .num       (m1_sum[FixNumW-1:0]),
    .in_item   (m1_item),
    .out_valid (fd_valid),
    .out_item  (fd_item)
  );

  // m * delta_j + fix
  bsas_mul u_mul_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fd_valid),
    .a         (fd_item.m),
    .b         (delta_of(cfg_r, fd_item.idx)),
    .c         (fd_item.fix),
    .in_item   (fd_item),
    .out_valid (m2_valid),
    .out_sum   (m2_sum),
    .out_item  (m2_item)
  );

  bsas_mod_div u_mod_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .cfg        (cfg_r),
    .in_valid   (m2_valid),
    .num        (m2_sum),
    .in_item    (m2_item),
    .out_valid  (md_valid),
    .out_scaled (md_scaled),
    .out_item   (md_item)
  );

  // Final modular add or subtract
  always_comb begin
    sel_mod  = mod_of(cfg_r, md_item.idx);
    add_sum  = {1'b0, md_item.res} + {1'b0, md_scaled};
    sub_wrap = {1'b0, md_item.res} + {1'b0, sel_mod} - {1'b0, md_scaled};
    if (!idx_ok(md_item.idx)) begin
      res_nxt = md_item.res;
    end else if (sel_mod < 61'd2) begin
      res_nxt = '0;
    end else if (md_item.op == OpAdd) begin
      res_nxt = (add_sum >= {1'b0, sel_mod}) ? ModW'(add_sum - {1'b0, sel_mod})
                                             : add_sum[ModW-1:0];
    end else begin
      res_nxt = (md_item.res >= md_scaled) ? ModW'(md_item.res - md_scaled)
                                           : sub_wrap[ModW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= md_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_residue_r <= res_nxt;
      out_idx_r     <= md_item.idx;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_residue_out = out_residue_r;

  // A held output beat must freeze the input side
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> in_stall)
    else $error("input accepted while output beat is held");

  // Results for an in-range modulus are reduced
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && idx_ok(out_idx_r)) |->
      ((mod_of(cfg_r, out_idx_r) < 61'd2) ? (out_residue_r == '0)
                                          : (out_residue_r < mod_of(cfg_r, out_idx_r))))
    else $error("result not reduced by its modulus");

  // No result right after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid right after reset");

endmodule

[verif/bfv_scaled_plain_add_sub_test.sv]
`timescale 1ns / 1ps

module bfv_scaled_plain_add_sub_test;
  import bsas_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 300;
  localparam logic [63:0] PlainMax = 64'h0FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CoeffMax = 64'h0FFF_FFFF_FFFF_FFFE;
  localparam logic [63:0] ModMax = 64'h1FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ResMax = 64'h1FFF_FFFF_FFFF_FFFE;

  typedef struct packed {
    logic              op;
    logic [PlainW-1:0] m;
    logic [1:0]        idx;
    logic [ModW-1:0]   res;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = OpAdd;
  logic [PlainW-1:0] in_plain_coeff = '0;
  logic [1:0] in_modulus_index = '0;
  logic [ModW-1:0] in_residue_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ModW-1:0] out_residue_out;
  logic cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ModW-1:0] cfg_wr_data = '0;

  cfg_t scale_cfg;
  beat_t pending_beats[$];
  logic [ModW-1:0] expected_residues[$];
  int mismatches = 0;
  int checked = 0;
  int phases = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  bfv_scaled_plain_add_sub DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_plain_coeff(in_plain_coeff),
    .in_modulus_index(in_modulus_index), .in_residue_in(in_residue_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_residue_out(out_residue_out),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Scaled plaintext add/sub in 128-bit arithmetic
  function automatic logic [ModW-1:0] scaled_residue(input cfg_t c, input beat_t b);
    logic [127:0] md, dl, t, q, m, fix, scaled, r;
    if (b.idx >= NumModuli) return b.res;
    case (b.idx)
      2'd0: begin
        md = 128'(c.modulus_zero);
        dl = 128'(c.delta_zero);
      end
      2'd1: begin
        md = 128'(c.modulus_one);
        dl = 128'(c.delta_one);
      end
      default: begin
        md = 128'(c.modulus_two);
        dl = 128'(c.delta_two);
      end
    endcase
    if (md < 2) return '0;
    t = 128'(c.pt_modulus);
    q = 128'(c.q_mod_plain);
    m = 128'(b.m);
    fix = '0;
    if (t != 0) begin
      fix = (q * m + ((t + 1) >> 1)) / t;
      fix = {64'd0, fix[63:0]};
    end
    scaled = (m * dl + fix) % md;
    r = 128'(b.res) % md;
    if (b.op == OpAdd) begin
      r = r + scaled;
      if (r >= md) r = r - md;
    end else begin
      r = (r >= scaled) ? (r - scaled) : (r + md - scaled);
    end
    return r[ModW-1:0];
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_span(input logic [63:0] lo, input logic [63:0] hi);
    return lo + rand64() % (hi - lo + 1);
  endfunction

  // Sender: bursts with random gaps, payload held while stalled
  always @(posedge clk) begin
    beat_t b;
    if (in_valid && !in_stall) begin
      b = '{op: in_opcode, m: in_plain_coeff, idx: in_modulus_index, res: in_residue_in};
      expected_residues.push_back(scaled_residue(scale_cfg, b));
    end
    if (rst_n && !(in_valid && in_stall)) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        b = pending_beats.pop_front();
        burst_left--;
        in_valid <= 1'b1;
        in_opcode <= b.op;
        in_plain_coeff <= b.m;
        in_modulus_index <= b.idx;
        in_residue_in <= b.res;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: check each beat, stall in modes that change over time
  always @(posedge clk) begin
    logic [ModW-1:0] want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_residues.size());
      $display("FAIL");
      $finish;
    end
    if (out_valid && !out_stall) begin
      if (expected_residues.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: residue_out=%0h", out_residue_out);
      end else begin
        want = expected_residues.pop_front();
        checked++;
        if (out_residue_out !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("residue_out mismatch: expected %0h, got %0h", want, out_residue_out);
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((cycles % 8) < 3);
    endcase
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val[ModW-1:0];
    case (idx)
      CfgPlainModulus: scale_cfg.pt_modulus = val[PlainW-1:0];
      CfgQModPlain:    scale_cfg.q_mod_plain = val[PlainW-1:0];
      CfgModulusZero:  scale_cfg.modulus_zero = val[ModW-1:0];
      CfgModulusOne:   scale_cfg.modulus_one = val[ModW-1:0];
      CfgModulusTwo:   scale_cfg.modulus_two = val[ModW-1:0];
      CfgDeltaZero:    scale_cfg.delta_zero = val[ModW-1:0];
      CfgDeltaOne:     scale_cfg.delta_one = val[ModW-1:0];
      default:         scale_cfg.delta_two = val[ModW-1:0];
    endcase
  endtask

  task automatic load_setting(input logic [63:0] t, input logic [63:0] q,
                              input logic [63:0] m0, input logic [63:0] m1,
                              input logic [63:0] m2, input logic [63:0] d0,
                              input logic [63:0] d1, input logic [63:0] d2);
    write_reg(CfgPlainModulus, t);
    write_reg(CfgQModPlain, q);
    write_reg(CfgModulusZero, m0);
    write_reg(CfgModulusOne, m1);
    write_reg(CfgModulusTwo, m2);
    write_reg(CfgDeltaZero, d0);
    write_reg(CfgDeltaOne, d1);
    write_reg(CfgDeltaTwo, d2);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic queue_beat(input logic op, input logic [63:0] m, input logic [1:0] idx,
                            input logic [63:0] res);
    beat_t b;
    b = '{op: op, m: m[PlainW-1:0], idx: idx, res: res[ModW-1:0]};
    pending_beats.push_back(b);
  endtask

  function automatic logic [63:0] modulus_at(input logic [1:0] idx);
    case (idx)
      2'd0: return 64'(scale_cfg.modulus_zero);
      2'd1: return 64'(scale_cfg.modulus_one);
      default: return 64'(scale_cfg.modulus_two);
    endcase
  endfunction

  // Mostly reduced operands, a few out of range ones and the spare index
  task automatic queue_random(input int n);
    logic [63:0] m, res, mhi;
    logic [1:0] idx;
    for (int i = 0; i < n; i++) begin
      idx = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      mhi = (64'(scale_cfg.pt_modulus) - 64'd1 > CoeffMax) ? CoeffMax
                                                           : 64'(scale_cfg.pt_modulus) - 64'd1;
      m = ($urandom_range(0, 4) == 0) ? rand_span(0, CoeffMax) : rand_span(0, mhi);
      res = ($urandom_range(0, 6) == 0 || idx == 2'd3) ? rand_span(0, ResMax)
                                                      : rand_span(0, modulus_at(idx) - 1);
      queue_beat($urandom_range(0, 1) ? OpSub : OpAdd, m, idx, res);
    end
  endtask

  // Release the queued beats, then wait until the pipeline is empty
  task automatic run_phase();
    phases++;
    do @(posedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_residues.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    logic [63:0] t, m0, m1, m2;
    scale_cfg = '{pt_modulus: 60'd65537, q_mod_plain: '0,
                  modulus_zero: 61'd2, modulus_one: 61'd2, modulus_two: 61'd2,
                  delta_zero: '0, delta_one: '0, delta_two: '0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: every modulus is two
    for (int i = 0; i < 4; i++) begin
      queue_beat(OpAdd, 64'd65536, 2'(i), 64'd1);
      queue_beat(OpSub, 64'd0, 2'(i), 64'd1);
    end
    run_phase();

    // Extremes of every register and field, spare index passes residue through
    load_setting(PlainMax, PlainMax - 1, ModMax, ModMax - 2, 64'd2,
                 ModMax - 1, 64'd0, 64'd1);
    queue_beat(OpAdd, CoeffMax, 2'd0, ResMax);
    queue_beat(OpSub, CoeffMax, 2'd0, 64'd0);
    queue_beat(OpAdd, 64'd0, 2'd0, 64'd0);
    queue_beat(OpSub, 64'd1, 2'd1, ModMax - 3);
    queue_beat(OpAdd, CoeffMax, 2'd1, ResMax);
    queue_beat(OpSub, CoeffMax, 2'd2, 64'd1);
    queue_beat(OpAdd, CoeffMax, 2'd2, ResMax);
    queue_beat(OpAdd, CoeffMax, 2'd3, ResMax);
    queue_beat(OpSub, 64'd0, 2'd3, 64'd0);
    run_phase();

    // Smallest plaintext modulus: unreduced coefficients make a huge fix
    load_setting(64'd2, 64'd1, 64'd3, 64'd5, 64'd7, 64'd2, 64'd4, 64'd6);
    queue_beat(OpAdd, 64'd1, 2'd0, 64'd2);
    queue_beat(OpSub, 64'd1, 2'd1, 64'd0);
    queue_beat(OpAdd, CoeffMax, 2'd2, 64'd6);
    queue_beat(OpSub, CoeffMax, 2'd0, ResMax);
    queue_beat(OpAdd, 64'd0, 2'd1, 64'd4);
    run_phase();

    // Random settings with random content
    for (int p = 0; p < 8; p++) begin
      t = (p % 2 == 0) ? rand_span(2, 70000) : rand_span(2, PlainMax);
      m0 = (p % 3 == 0) ? rand_span(2, 1000) : rand_span(2, ModMax);
      m1 = rand_span(2, ModMax);
      m2 = (p == 5) ? ModMax : rand_span(2, ModMax);
      load_setting(t, rand_span(0, t - 1), m0, m1, m2,
                   rand_span(0, m0 - 1), rand_span(0, m1 - 1), rand_span(0, m2 - 1));
      queue_random(48);
      run_phase();
    end

    $display("checked %0d result beats over %0d register settings, %0d mismatches",
             checked, phases, mismatches);
    if (mismatches == 0 && expected_residues.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
